// ----- sv/utd_pkg.sv -----
package utd_pkg;

  // Fixed field widths of the ports
  localparam int TERM_COUNT_W = 3;
  localparam int ROW_WIDTH_W  = 3;
  localparam int ROW_COUNT_W  = 7;

  // Number of term ports on the command channel
  localparam int IN_SLOTS = 4;

  // Row width after reset
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 3'd4;

  // Command modes
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// ----- sv/utd_ram.sv -----
module utd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/utd_match.sv -----
module utd_match #(
  parameter int MAX_TERMS  = 4,
  parameter int TERM_WIDTH = 16,
  parameter int CW         = $clog2(MAX_TERMS + 1)
) (
  input  logic [MAX_TERMS*TERM_WIDTH-1:0] row,
  input  logic [MAX_TERMS*TERM_WIDTH-1:0] fresh,
  input  logic [CW-1:0]                   count,
  output logic                            hit
);

  // Multiset compare of the first count slots: every new term must occur
  // as often in the row prefix as in the new tuple. Equal sizes make this
  // sufficient.
  always_comb begin
    logic [CW-1:0] n_row;
    logic [CW-1:0] n_new;
    hit = 1'b1;
    for (int i = 0; i < MAX_TERMS; i++) begin
      n_row = '0;
      n_new = '0;
      for (int j = 0; j < MAX_TERMS; j++) begin
        if (j < int'(count)) begin
          if (row[j*TERM_WIDTH +: TERM_WIDTH] == fresh[i*TERM_WIDTH +: TERM_WIDTH]) begin
            n_row = n_row + CW'(1);
          end
          if (fresh[j*TERM_WIDTH +: TERM_WIDTH] == fresh[i*TERM_WIDTH +: TERM_WIDTH]) begin
            n_new = n_new + CW'(1);
          end
        end
      end
      if (i < int'(count) && n_row != n_new) begin
        hit = 1'b0;
      end
    end
  end

endmodule

// ----- sv/unordered_tuple_history_dedup.sv -----
// Channel   | Transfer when         | Signals
// ----------+-----------------------+-------------------------------------------
// command   | start && !busy        | mode, term_count, term_0..term_3
// result    | done (one cycle)      | stale, recorded, history_full, row_count
// config    | row_width_we          | row_width
//
// A clear command returns its result in the next cycle and keeps busy low.
// A check scans the stored rows out of the history RAM, one row per cycle
// through its single registered read port; busy stays high until the last
// row has been compared or a row matches early, and the result shows in the
// same cycle that busy falls.
// Reset empties the history and sets row_width to 4; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per command.
module unordered_tuple_history_dedup import utd_pkg::*; #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_TERMS     = 4,
  parameter int TERM_WIDTH    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [TERM_COUNT_W-1:0]       term_count,
  input  logic signed [TERM_WIDTH-1:0]  term_0,
  input  logic signed [TERM_WIDTH-1:0]  term_1,
  input  logic signed [TERM_WIDTH-1:0]  term_2,
  input  logic signed [TERM_WIDTH-1:0]  term_3,
  input  logic                          row_width_we,
  input  logic [ROW_WIDTH_W-1:0]        row_width,
  output logic                          done,
  output logic                          stale,
  output logic                          recorded,
  output logic                          history_full,
  output logic [ROW_COUNT_W-1:0]        row_count
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int DW = MAX_TERMS * TERM_WIDTH;
  localparam logic [TERM_WIDTH-1:0] PAD = {1'b1, {(TERM_WIDTH-1){1'b0}}};

  state_t                                state;
  logic [RW-1:0]                         rows_used;
  logic [RW-1:0]                         iss;
  logic                                  rd_pending;
  logic [ROW_WIDTH_W-1:0]                width_cfg;
  logic [MAX_TERMS-1:0][TERM_WIDTH-1:0]  fresh;
  logic [MAX_TERMS-1:0][TERM_WIDTH-1:0]  fresh_next;
  logic [CW-1:0]                         cnt;
  logic [CW-1:0]                         cnt_next;
  logic [IN_SLOTS-1:0][TERM_WIDTH-1:0]   in_terms;
  logic [MAX_TERMS-1:0][TERM_WIDTH-1:0]  wdata;
  logic [DW-1:0]                         rdata;
  logic                                  row_match;
  logic                                  hit;
  logic                                  issue;
  logic                                  re;
  logic                                  we;
  logic                                  at_cap;

  assign in_terms = {term_3, term_2, term_1, term_0};
  assign busy     = (state != S_IDLE);

  // Incoming tuple: slots beyond the term ports hold pad, count saturates
  always_comb begin
    int c;
    for (int i = 0; i < MAX_TERMS; i++) begin
      fresh_next[i] = (i < IN_SLOTS) ? in_terms[i % IN_SLOTS] : PAD;
    end
    c = int'(term_count);
    if (c > MAX_TERMS) begin
      c = MAX_TERMS;
    end
    cnt_next = CW'(c);
  end

  // Row to append: terms below both width and count, pad elsewhere
  always_comb begin
    int w;
    w = int'(width_cfg);
    if (w < 1) begin
      w = 1;
    end
    if (w > MAX_TERMS) begin
      w = MAX_TERMS;
    end
    for (int i = 0; i < MAX_TERMS; i++) begin
      wdata[i] = (i < w && i < int'(cnt)) ? fresh[i] : PAD;
    end
  end

  // Scan control
  assign issue  = (iss < rows_used);
  assign re     = (state == S_SCAN) && issue;
  assign hit    = rd_pending && row_match;
  assign at_cap = (rows_used >= RW'(HISTORY_DEPTH));
  assign we     = (state == S_SCAN) && !hit && !issue && !at_cap;

  utd_ram #(
    .WIDTH (DW),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rows_used[AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (iss[AW-1:0]),
    .rdata (rdata)
  );

  utd_match #(
    .MAX_TERMS  (MAX_TERMS),
    .TERM_WIDTH (TERM_WIDTH)
  ) u_match (
    .row   (rdata),
    .fresh (fresh),
    .count (cnt),
    .hit   (row_match)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rows_used  <= '0;
      iss        <= '0;
      rd_pending <= 1'b0;
      width_cfg  <= ROW_WIDTH_RESET;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      rd_pending <= re;
      if (row_width_we) begin
        width_cfg <= row_width;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_CLEAR) begin
              // clear command
              rows_used    <= '0;
              done         <= 1'b1;
              stale        <= 1'b0;
              recorded     <= 1'b0;
              history_full <= 1'b0;
              row_count    <= '0;
            end else begin
              fresh <= fresh_next;
              cnt   <= cnt_next;
              iss   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (re) begin
            iss <= iss + RW'(1);
          end
          if (hit) begin
            done         <= 1'b1;
            stale        <= 1'b1;
            recorded     <= 1'b0;
            history_full <= 1'b0;
            row_count    <= ROW_COUNT_W'(rows_used);
            state        <= S_IDLE;
          end else if (!issue) begin
            // last row checked without a match
            done  <= 1'b1;
            stale <= 1'b0;
            if (at_cap) begin
              history_full <= 1'b1;
              recorded     <= 1'b0;
              row_count    <= ROW_COUNT_W'(rows_used);
            end else begin
              rows_used    <= rows_used + RW'(1);
              history_full <= 1'b0;
              recorded     <= 1'b1;
              row_count    <= ROW_COUNT_W'(rows_used + RW'(1));
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/utd_checker.sv -----
module utd_checker import utd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   mode,
  input logic                   done,
  input logic                   stale,
  input logic                   recorded,
  input logic                   history_full,
  input logic [ROW_COUNT_W-1:0] row_count
);

  // A clear answers in the next cycle with an empty history
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_CLEAR) |=> (done && row_count == '0 && !stale
                                               && !recorded && !history_full))
    else $error("clear result missing or wrong");

  // A check always starts a scan instead of answering at once
  a_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_CHECK) |=> (busy && !done))
    else $error("check did not start a scan");

  // Outcome flags exclude each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({stale, recorded, history_full}))
    else $error("conflicting result flags");

  // A result only follows a transfer or a scan
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result without a command");

endmodule

bind unordered_tuple_history_dedup utd_checker u_chk (.*);
